[rtl/clbl_pkg.sv]
// ----------------------------------------------------------------------------
// clbl_pkg
// Shared types, register map and constants of the clipped line generator.
// ----------------------------------------------------------------------------
package clbl_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int ADDR_BITS_DEF  = 20;

    // configuration registers
    localparam int REG_W   = 11;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 5;
    localparam int IDX_W   = 3;

    // queue depths
    localparam int CMDQ_DEPTH = 4;
    localparam int OUTQ_DEPTH = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_CLIP_LEFT    = 3'd2,
        REG_CLIP_TOP     = 3'd3,
        REG_CLIP_RIGHT   = 3'd4,
        REG_CLIP_BOTTOM  = 3'd5
    } t_reg_idx;

    localparam logic [REG_W-1:0] RST_FRAME_WIDTH  = 11'd320;
    localparam logic [REG_W-1:0] RST_FRAME_HEIGHT = 11'd240;
    localparam logic [REG_W-1:0] RST_CLIP_LEFT    = 11'd0;
    localparam logic [REG_W-1:0] RST_CLIP_TOP     = 11'd0;
    localparam logic [REG_W-1:0] RST_CLIP_RIGHT   = 11'd320;
    localparam logic [REG_W-1:0] RST_CLIP_BOTTOM  = 11'd240;

    typedef enum logic {
        CMD_BEGIN   = 1'b0,
        CMD_ADVANCE = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [REG_W-1:0] frame_width;
        logic [REG_W-1:0] frame_height;
        logic [REG_W-1:0] clip_left;
        logic [REG_W-1:0] clip_top;
        logic [REG_W-1:0] clip_right;
        logic [REG_W-1:0] clip_bottom;
    } t_cfg;

    // classification of one queued command
    typedef struct packed {
        t_cmd cmd;
        logic neg_x;
        logic neg_y;
        logic x_major;
    } t_line_ctl;

endpackage

[rtl/clbl_cfg.sv]
// ----------------------------------------------------------------------------
// clbl_cfg
// APB register file holding frame size and clip rectangle.
// ----------------------------------------------------------------------------
module clbl_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [clbl_pkg::PADDR_W-1:0]       paddr,
    input  logic [clbl_pkg::DATA_W-1:0]        pwdata,
    output logic [clbl_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    output clbl_pkg::t_cfg                     o_cfg
);

    localparam int PAD_W = clbl_pkg::DATA_W - clbl_pkg::REG_W;

    clbl_pkg::t_cfg                   r_cfg;
    logic [clbl_pkg::IDX_W-1:0]       idx;
    logic                             wr;
    logic [clbl_pkg::REG_W-1:0]       wval;
    logic [clbl_pkg::REG_W-1:0]       rval;

    assign idx   = paddr[clbl_pkg::PADDR_W-1:2];
    assign wr    = psel & penable & pwrite;
    assign wval  = pwdata[clbl_pkg::REG_W-1:0];
    assign pready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= clbl_pkg::RST_FRAME_WIDTH;
            r_cfg.frame_height <= clbl_pkg::RST_FRAME_HEIGHT;
            r_cfg.clip_left    <= clbl_pkg::RST_CLIP_LEFT;
            r_cfg.clip_top     <= clbl_pkg::RST_CLIP_TOP;
            r_cfg.clip_right   <= clbl_pkg::RST_CLIP_RIGHT;
            r_cfg.clip_bottom  <= clbl_pkg::RST_CLIP_BOTTOM;
        end else if (wr) begin
            unique case (idx)
                clbl_pkg::REG_FRAME_WIDTH:  r_cfg.frame_width  <= wval;
                clbl_pkg::REG_FRAME_HEIGHT: r_cfg.frame_height <= wval;
                clbl_pkg::REG_CLIP_LEFT:    r_cfg.clip_left    <= wval;
                clbl_pkg::REG_CLIP_TOP:     r_cfg.clip_top     <= wval;
                clbl_pkg::REG_CLIP_RIGHT:   r_cfg.clip_right   <= wval;
                clbl_pkg::REG_CLIP_BOTTOM:  r_cfg.clip_bottom  <= wval;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            clbl_pkg::REG_FRAME_WIDTH:  rval = r_cfg.frame_width;
            clbl_pkg::REG_FRAME_HEIGHT: rval = r_cfg.frame_height;
            clbl_pkg::REG_CLIP_LEFT:    rval = r_cfg.clip_left;
            clbl_pkg::REG_CLIP_TOP:     rval = r_cfg.clip_top;
            clbl_pkg::REG_CLIP_RIGHT:   rval = r_cfg.clip_right;
            clbl_pkg::REG_CLIP_BOTTOM:  rval = r_cfg.clip_bottom;
            default:                    rval = '0;
        endcase
    end

    assign prdata = {{PAD_W{1'b0}}, rval};

endmodule

[rtl/clbl_front.sv]
// ----------------------------------------------------------------------------
// clbl_front
// Accepts commands, works out line setup for begin commands and queues them.
// ----------------------------------------------------------------------------
module clbl_front #(
    parameter int COORD_BITS = clbl_pkg::COORD_BITS_DEF,
    parameter int ADDR_BITS  = clbl_pkg::ADDR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [clbl_pkg::REG_W-1:0]    i_frame_width,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_cmd,
    input  logic [COORD_BITS-1:0]         i_start_x,
    input  logic [COORD_BITS-1:0]         i_start_y,
    input  logic [COORD_BITS-1:0]         i_end_x,
    input  logic [COORD_BITS-1:0]         i_end_y,
    input  logic [15:0]                   i_pen_color,
    output logic                          o_q_valid,
    input  logic                          i_q_pop,
    output clbl_pkg::t_line_ctl           o_q_ctl,
    output logic [COORD_BITS-1:0]         o_q_x,
    output logic [COORD_BITS-1:0]         o_q_y,
    output logic [COORD_BITS-1:0]         o_q_goal_x,
    output logic [COORD_BITS-1:0]         o_q_goal_y,
    output logic [15:0]                   o_q_color,
    output logic [COORD_BITS-1:0]         o_q_major,
    output logic [COORD_BITS-1:0]         o_q_minor,
    output logic [COORD_BITS:0]           o_q_err,
    output logic [ADDR_BITS+1:0]          o_q_addr
);

    localparam int C     = COORD_BITS;
    localparam int A2    = ADDR_BITS + 2;
    localparam int MW    = clbl_pkg::REG_W + C + 1;
    localparam int PW    = (A2 > MW) ? A2 : MW;
    localparam int DEPTH = clbl_pkg::CMDQ_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef struct packed {
        clbl_pkg::t_line_ctl ctl;
        logic [C-1:0]        x;
        logic [C-1:0]        y;
        logic [C-1:0]        gx;
        logic [C-1:0]        gy;
        logic [15:0]         color;
        logic [C-1:0]        major;
        logic [C-1:0]        minor;
        logic [C:0]          err;
        logic [A2-1:0]       addr;
    } t_entry;

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic [PTR_W-1:0]   n_wr;
    logic [PTR_W-1:0]   n_rd;
    logic [CNT_W-1:0]   n_cnt;

    logic               do_push;
    logic [C:0]         dx;
    logic [C:0]         dy;
    logic [C:0]         ndx;
    logic [C:0]         ndy;
    logic [C-1:0]       ax;
    logic [C-1:0]       ay;
    logic               x_major;
    logic [PW-1:0]      w_ext;
    logic [PW-1:0]      y_ext;
    logic [PW-1:0]      x_ext;
    logic [PW-1:0]      prod;
    logic [PW-1:0]      addr_full;
    t_entry             ent;
    t_entry             head;

    // line setup
    assign dx  = {i_end_x[C-1], i_end_x} - {i_start_x[C-1], i_start_x};
    assign dy  = {i_end_y[C-1], i_end_y} - {i_start_y[C-1], i_start_y};
    assign ndx = -dx;
    assign ndy = -dy;
    assign ax  = dx[C] ? ndx[C-1:0] : dx[C-1:0];
    assign ay  = dy[C] ? ndy[C-1:0] : dy[C-1:0];
    assign x_major = (ax >= ay);

    // start address width*y+x, low bits only
    assign w_ext     = {{(PW-clbl_pkg::REG_W){1'b0}}, i_frame_width};
    assign y_ext     = {{(PW-C){i_start_y[C-1]}}, i_start_y};
    assign x_ext     = {{(PW-C){i_start_x[C-1]}}, i_start_x};
    assign prod      = w_ext * y_ext;
    assign addr_full = prod + x_ext;

    always_comb begin
        ent.ctl.cmd     = clbl_pkg::t_cmd'(i_cmd);
        ent.ctl.neg_x   = dx[C];
        ent.ctl.neg_y   = dy[C];
        ent.ctl.x_major = x_major;
        ent.x           = i_start_x;
        ent.y           = i_start_y;
        ent.gx          = i_end_x;
        ent.gy          = i_end_y;
        ent.color       = i_pen_color;
        ent.major       = x_major ? ax : ay;
        ent.minor       = x_major ? ay : ax;
        ent.err         = {2'b00, ent.major[C-1:1]};
        ent.addr        = addr_full[A2-1:0];
    end

    // command queue
    assign full      = (r_cnt == CNT_W'(DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign do_push   = push & ~full;

    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !i_q_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!do_push && i_q_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= n_wr;
            end
            if (i_q_pop) begin
                r_rd <= n_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= ent;
        end
    end

    assign head       = r_mem[r_rd];
    assign o_q_ctl    = head.ctl;
    assign o_q_x      = head.x;
    assign o_q_y      = head.y;
    assign o_q_goal_x = head.gx;
    assign o_q_goal_y = head.gy;
    assign o_q_color  = head.color;
    assign o_q_major  = head.major;
    assign o_q_minor  = head.minor;
    assign o_q_err    = head.err;
    assign o_q_addr   = head.addr;

endmodule

[rtl/clbl_back.sv]
// ----------------------------------------------------------------------------
// clbl_back
// Steps the active line one pixel per advance and buffers the pixels.
// ----------------------------------------------------------------------------
module clbl_back #(
    parameter int COORD_BITS = clbl_pkg::COORD_BITS_DEF,
    parameter int ADDR_BITS  = clbl_pkg::ADDR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  clbl_pkg::t_cfg                i_cfg,
    input  logic                          i_q_valid,
    output logic                          o_q_pop,
    input  clbl_pkg::t_line_ctl           i_q_ctl,
    input  logic [COORD_BITS-1:0]         i_q_x,
    input  logic [COORD_BITS-1:0]         i_q_y,
    input  logic [COORD_BITS-1:0]         i_q_goal_x,
    input  logic [COORD_BITS-1:0]         i_q_goal_y,
    input  logic [15:0]                   i_q_color,
    input  logic [COORD_BITS-1:0]         i_q_major,
    input  logic [COORD_BITS-1:0]         i_q_minor,
    input  logic [COORD_BITS:0]           i_q_err,
    input  logic [ADDR_BITS+1:0]          i_q_addr,
    input  logic                          pop,
    output logic                          empty,
    output logic [COORD_BITS-1:0]         o_pixel_x,
    output logic [COORD_BITS-1:0]         o_pixel_y,
    output logic [ADDR_BITS-1:0]          o_pixel_address,
    output logic [15:0]                   o_pixel_color,
    output logic                          o_write_enable,
    output logic                          o_last
);

    localparam int C     = COORD_BITS;
    localparam int A2    = ADDR_BITS + 2;
    localparam int RW    = clbl_pkg::REG_W;
    localparam int EW    = (C > RW) ? C : RW;
    localparam int DEPTH = clbl_pkg::OUTQ_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [C-1:0]         x;
        logic [C-1:0]         y;
        logic [ADDR_BITS-1:0] addr;
        logic [15:0]          color;
        logic                 we;
        logic                 last;
    } t_pixel;

    // line state
    logic                 r_busy;
    logic [C-1:0]         r_x;
    logic [C-1:0]         r_y;
    logic [C-1:0]         r_gx;
    logic [C-1:0]         r_gy;
    logic [C:0]           r_err;
    logic [C-1:0]         r_major;
    logic [C-1:0]         r_minor;
    logic                 r_neg_x;
    logic                 r_neg_y;
    logic                 r_x_major;
    logic [A2-1:0]        r_addr;
    logic [15:0]          r_color;

    logic [C-1:0]         n_x;
    logic [C-1:0]         n_y;
    logic [C:0]           n_err;
    logic [A2-1:0]        n_addr;

    // pixel buffer
    t_pixel               r_mem [DEPTH];
    logic [PTR_W-1:0]     r_wr;
    logic [PTR_W-1:0]     r_rd;
    logic [CNT_W-1:0]     r_cnt;
    logic [CNT_W-1:0]     n_cnt;
    logic [PTR_W-1:0]     n_wr;
    logic [PTR_W-1:0]     n_rd;

    logic                 out_pop;
    logic                 space;
    logic                 is_begin;
    logic                 emit;
    logic                 fin;
    logic [C:0]           err_sub;
    logic                 take;
    logic                 step_x;
    logic                 step_y;
    logic [C-1:0]         inc_x;
    logic [C-1:0]         inc_y;
    logic [A2-1:0]        w_ext;
    logic [A2-1:0]        stride;
    logic [A2-1:0]        d_major;
    logic [A2-1:0]        d_minor;
    logic [RW-1:0]        right_b;
    logic [RW-1:0]        bottom_b;
    logic [EW-1:0]        x_e;
    logic [EW-1:0]        y_e;
    logic                 in_rect;
    t_pixel               pix;
    t_pixel               head;

    assign out_pop  = pop & ~empty;
    assign space    = (r_cnt != CNT_W'(DEPTH)) | out_pop;
    assign is_begin = (i_q_ctl.cmd == clbl_pkg::CMD_BEGIN);
    // an advance while idle is popped and dropped without giving a pixel
    assign o_q_pop  = i_q_valid & (is_begin | ~r_busy | space);
    assign emit     = i_q_valid & ~is_begin & r_busy & space;

    assign fin = r_x_major ? (r_x == r_gx) : (r_y == r_gy);

    // error term and minor step
    assign err_sub = r_err - {1'b0, r_minor};
    assign take    = err_sub[C];
    assign n_err   = take ? err_sub + {1'b0, r_major} : err_sub;
    assign step_x  = r_x_major | take;
    assign step_y  = ~r_x_major | take;

    assign inc_x = r_neg_x ? {C{1'b1}} : C'(1);
    assign inc_y = r_neg_y ? {C{1'b1}} : C'(1);
    assign n_x   = r_x + (step_x ? inc_x : '0);
    assign n_y   = r_y + (step_y ? inc_y : '0);

    assign w_ext   = {{(A2-RW){1'b0}}, i_cfg.frame_width};
    assign stride  = r_neg_y ? -w_ext : w_ext;
    assign d_major = step_x ? (r_neg_x ? {A2{1'b1}} : A2'(1)) : '0;
    assign d_minor = step_y ? stride : '0;
    assign n_addr  = r_addr + d_major + d_minor;

    // clip test against the frame-limited rectangle
    assign right_b  = (i_cfg.clip_right < i_cfg.frame_width) ?
                      i_cfg.clip_right : i_cfg.frame_width;
    assign bottom_b = (i_cfg.clip_bottom < i_cfg.frame_height) ?
                      i_cfg.clip_bottom : i_cfg.frame_height;
    assign x_e = EW'(r_x);
    assign y_e = EW'(r_y);
    assign in_rect = ~r_x[C-1] & ~r_y[C-1]
                   & (x_e >= EW'(i_cfg.clip_left)) & (x_e < EW'(right_b))
                   & (y_e >= EW'(i_cfg.clip_top))  & (y_e < EW'(bottom_b));

    always_comb begin
        pix.x     = r_x;
        pix.y     = r_y;
        pix.addr  = r_addr[ADDR_BITS-1:0];
        pix.color = r_color;
        pix.we    = in_rect;
        pix.last  = fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_q_pop && is_begin) begin
            r_busy <= 1'b1;
        end else if (emit && fin) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && is_begin) begin
            r_x       <= i_q_x;
            r_y       <= i_q_y;
            r_gx      <= i_q_goal_x;
            r_gy      <= i_q_goal_y;
            r_err     <= i_q_err;
            r_major   <= i_q_major;
            r_minor   <= i_q_minor;
            r_neg_x   <= i_q_ctl.neg_x;
            r_neg_y   <= i_q_ctl.neg_y;
            r_x_major <= i_q_ctl.x_major;
            r_addr    <= i_q_addr;
            r_color   <= i_q_color;
        end else if (emit && !fin) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_err  <= n_err;
            r_addr <= n_addr;
        end
    end

    // pixel buffer
    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_comb begin
        n_cnt = r_cnt;
        if (emit && !out_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!emit && out_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (emit) begin
                r_wr <= n_wr;
            end
            if (out_pop) begin
                r_rd <= n_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_mem[r_wr] <= pix;
        end
    end

    assign head            = r_mem[r_rd];
    assign empty           = (r_cnt == '0);
    assign o_pixel_x       = head.x;
    assign o_pixel_y       = head.y;
    assign o_pixel_address = head.addr;
    assign o_pixel_color   = head.color;
    assign o_write_enable  = head.we;
    assign o_last          = head.last;

endmodule

[rtl/clipped_bresenham_line.sv]
// ----------------------------------------------------------------------------
// clipped_bresenham_line
// Bresenham line generator with clip rectangle and linear pixel addressing.
// ----------------------------------------------------------------------------
// Takes one command per clock while the command queue is not full. A begin
// command loads a line and gives no pixel; each advance on an active line
// gives one pixel, so a line of n pixels costs n+1 commands. The pixel rate
// is set by the back end's step (error update, coordinate and address adders,
// clip compare); the start address multiply sits in the front end. A
// four-entry command queue sits between the two, and a two-entry pixel buffer
// drives the result ports; a pixel is registered in the buffer before it
// shows on the result side.
// ----------------------------------------------------------------------------
module clipped_bresenham_line #(
    parameter int COORD_BITS = clbl_pkg::COORD_BITS_DEF,
    parameter int ADDR_BITS  = clbl_pkg::ADDR_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [clbl_pkg::PADDR_W-1:0]         paddr,
    input  logic [clbl_pkg::DATA_W-1:0]          pwdata,
    output logic [clbl_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready,
    // commands
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 i_cmd,
    input  logic signed [COORD_BITS-1:0]         i_start_x,
    input  logic signed [COORD_BITS-1:0]         i_start_y,
    input  logic signed [COORD_BITS-1:0]         i_end_x,
    input  logic signed [COORD_BITS-1:0]         i_end_y,
    input  logic [15:0]                          i_pen_color,
    // pixels
    input  logic                                 pop,
    output logic                                 empty,
    output logic signed [COORD_BITS-1:0]         o_pixel_x,
    output logic signed [COORD_BITS-1:0]         o_pixel_y,
    output logic [ADDR_BITS-1:0]                 o_pixel_address,
    output logic [15:0]                          o_pixel_color,
    output logic                                 o_write_enable,
    output logic                                 o_last
);

    clbl_pkg::t_cfg          cfg;
    clbl_pkg::t_line_ctl     q_ctl;
    logic                    q_valid;
    logic                    q_pop;
    logic [COORD_BITS-1:0]   q_x;
    logic [COORD_BITS-1:0]   q_y;
    logic [COORD_BITS-1:0]   q_goal_x;
    logic [COORD_BITS-1:0]   q_goal_y;
    logic [15:0]             q_color;
    logic [COORD_BITS-1:0]   q_major;
    logic [COORD_BITS-1:0]   q_minor;
    logic [COORD_BITS:0]     q_err;
    logic [ADDR_BITS+1:0]    q_addr;
    logic [COORD_BITS-1:0]   px;
    logic [COORD_BITS-1:0]   py;

    clbl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    clbl_front #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame_width (cfg.frame_width),
        .push          (push),
        .full          (full),
        .i_cmd         (i_cmd),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_pen_color   (i_pen_color),
        .o_q_valid     (q_valid),
        .i_q_pop       (q_pop),
        .o_q_ctl       (q_ctl),
        .o_q_x         (q_x),
        .o_q_y         (q_y),
        .o_q_goal_x    (q_goal_x),
        .o_q_goal_y    (q_goal_y),
        .o_q_color     (q_color),
        .o_q_major     (q_major),
        .o_q_minor     (q_minor),
        .o_q_err       (q_err),
        .o_q_addr      (q_addr)
    );

    clbl_back #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_q_valid       (q_valid),
        .o_q_pop         (q_pop),
        .i_q_ctl         (q_ctl),
        .i_q_x           (q_x),
        .i_q_y           (q_y),
        .i_q_goal_x      (q_goal_x),
        .i_q_goal_y      (q_goal_y),
        .i_q_color       (q_color),
        .i_q_major       (q_major),
        .i_q_minor       (q_minor),
        .i_q_err         (q_err),
        .i_q_addr        (q_addr),
        .pop             (pop),
        .empty           (empty),
        .o_pixel_x       (px),
        .o_pixel_y       (py),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_write_enable  (o_write_enable),
        .o_last          (o_last)
    );

    assign o_pixel_x = px;
    assign o_pixel_y = py;

endmodule

[rtl/clbl_checker.sv]
// ----------------------------------------------------------------------------
// clbl_checker
// Port-level checks of the line generator, bound to the top level.
// ----------------------------------------------------------------------------
module clbl_checker #(
    parameter int COORD_BITS = clbl_pkg::COORD_BITS_DEF,
    parameter int ADDR_BITS  = clbl_pkg::ADDR_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         push,
    input logic                         full,
    input logic                         pop,
    input logic                         empty,
    input logic [COORD_BITS-1:0]        o_pixel_x,
    input logic [COORD_BITS-1:0]        o_pixel_y,
    input logic [ADDR_BITS-1:0]         o_pixel_address,
    input logic                         o_write_enable,
    input logic                         o_last
);

    // reset leaves both queues drained
    a_reset_drained: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not drained after reset");

    // a pixel inside the clip rectangle never has a negative coordinate
    a_we_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_write_enable |-> !o_pixel_x[COORD_BITS-1] && !o_pixel_y[COORD_BITS-1])
        else $error("write enabled on negative coordinate");

    // a waiting pixel holds until its transfer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_pixel_address) && $stable(o_last))
        else $error("waiting pixel changed before transfer");

    // with no command taken and no pixel taken, the pixel side can only fill
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop && !(push && !full) |=> !empty)
        else $error("pixel lost without transfer");

endmodule

bind clipped_bresenham_line clbl_checker #(
    .COORD_BITS (COORD_BITS),
    .ADDR_BITS  (ADDR_BITS)
) u_clbl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .push            (push),
    .full            (full),
    .pop             (pop),
    .empty           (empty),
    .o_pixel_x       (o_pixel_x),
    .o_pixel_y       (o_pixel_y),
    .o_pixel_address (o_pixel_address),
    .o_write_enable  (o_write_enable),
    .o_last          (o_last)
);

[dv/clipped_bresenham_line_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clipped_bresenham_line_check
// Watches the register port, the command queue and the pixel queue of the
// line generator, predicts every pixel and compares it field by field.
// ----------------------------------------------------------------------------
module clipped_bresenham_line_check
    import clbl_pkg::*;
(
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [PADDR_W-1:0]                paddr,
    input  logic [DATA_W-1:0]                 pwdata,
    input  logic                              pready,
    // commands
    input  logic                              push,
    input  logic                              full,
    input  logic                              i_cmd,
    input  logic signed [COORD_BITS_DEF-1:0]  i_start_x,
    input  logic signed [COORD_BITS_DEF-1:0]  i_start_y,
    input  logic signed [COORD_BITS_DEF-1:0]  i_end_x,
    input  logic signed [COORD_BITS_DEF-1:0]  i_end_y,
    input  logic [15:0]                       i_pen_color,
    // pixels
    input  logic                              pop,
    input  logic                              empty,
    input  logic signed [COORD_BITS_DEF-1:0]  i_pixel_x,
    input  logic signed [COORD_BITS_DEF-1:0]  i_pixel_y,
    input  logic [ADDR_BITS_DEF-1:0]          i_pixel_address,
    input  logic [15:0]                       i_pixel_color,
    input  logic                              i_write_enable,
    input  logic                              i_last,
    // status
    output int                                o_fail_count,
    output int                                o_pending
);

    localparam int CW = COORD_BITS_DEF;
    localparam int AW = ADDR_BITS_DEF;
    localparam int MAX_PRINTS = 100;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [AW-1:0]        address;
        logic [15:0]          color;
        logic                 write_en;
        logic                 is_last;
    } t_pixel;

    t_pixel expected_pixels[$];

    // register copies
    logic [REG_W-1:0] frame_w, frame_h, clip_l, clip_t, clip_r, clip_b;

    // line walker state
    bit            line_active;
    int            pos_x, pos_y, goal_x, goal_y;
    int            err_acc, major_len, minor_len;
    bit            neg_x, neg_y, x_major;
    logic [AW+1:0] addr_acc;
    logic [15:0]   line_color;

    task automatic report(string what);
        if (o_fail_count < MAX_PRINTS) begin
            $display("%0t: mismatch: %s", $realtime, what);
        end
        o_fail_count++;
    endtask

    task automatic reset_walker();
        frame_w     = RST_FRAME_WIDTH;
        frame_h     = RST_FRAME_HEIGHT;
        clip_l      = RST_CLIP_LEFT;
        clip_t      = RST_CLIP_TOP;
        clip_r      = RST_CLIP_RIGHT;
        clip_b      = RST_CLIP_BOTTOM;
        line_active = 1'b0;
        pos_x       = 0;
        pos_y       = 0;
        goal_x      = 0;
        goal_y      = 0;
        err_acc     = 0;
        major_len   = 0;
        minor_len   = 0;
        neg_x       = 1'b0;
        neg_y       = 1'b0;
        x_major     = 1'b0;
        addr_acc    = '0;
        line_color  = '0;
    endtask

    task automatic write_setting(t_reg_idx idx, logic [REG_W-1:0] value);
        case (idx)
            REG_FRAME_WIDTH:  frame_w = value;
            REG_FRAME_HEIGHT: frame_h = value;
            REG_CLIP_LEFT:    clip_l  = value;
            REG_CLIP_TOP:     clip_t  = value;
            REG_CLIP_RIGHT:   clip_r  = value;
            REG_CLIP_BOTTOM:  clip_b  = value;
            default: ;
        endcase
    endtask

    task automatic load_line(int sx, int sy, int ex, int ey, logic [15:0] color);
        int dx, dy, ax, ay, start_addr;
        pos_x      = sx;
        pos_y      = sy;
        goal_x     = ex;
        goal_y     = ey;
        line_color = color;
        dx         = ex - sx;
        dy         = ey - sy;
        neg_x      = dx < 0;
        neg_y      = dy < 0;
        ax         = neg_x ? -dx : dx;
        ay         = neg_y ? -dy : dy;
        x_major    = ax >= ay;
        major_len  = x_major ? ax : ay;
        minor_len  = x_major ? ay : ax;
        err_acc    = major_len / 2;
        // two's complement product, kept modulo the wider address accumulator
        start_addr = int'(frame_w) * sy + sx;
        addr_acc   = (AW+2)'(start_addr);
        line_active = 1'b1;
    endtask

    function automatic bit in_clip(int x, int y);
        int right_edge, bottom_edge;
        right_edge  = (clip_r < frame_w) ? int'(clip_r) : int'(frame_w);
        bottom_edge = (clip_b < frame_h) ? int'(clip_b) : int'(frame_h);
        if (x < 0 || y < 0) begin
            return 1'b0;
        end
        return x >= int'(clip_l) && x < right_edge &&
               y >= int'(clip_t) && y < bottom_edge;
    endfunction

    function automatic t_pixel next_pixel();
        t_pixel px;
        bit     at_goal;
        int     sx, sy, stride;
        at_goal = x_major ? (pos_x == goal_x) : (pos_y == goal_y);
        sx      = neg_x ? -1 : 1;
        sy      = neg_y ? -1 : 1;
        stride  = int'(frame_w) * sy;

        px.x        = CW'(pos_x);
        px.y        = CW'(pos_y);
        px.address  = addr_acc[AW-1:0];
        px.color    = line_color;
        px.write_en = in_clip(pos_x, pos_y);
        px.is_last  = at_goal;

        if (at_goal) begin
            line_active = 1'b0;
            return px;
        end
        if (x_major) begin
            pos_x    += sx;
            addr_acc = addr_acc + (AW+2)'(sx);
        end else begin
            pos_y    += sy;
            addr_acc = addr_acc + (AW+2)'(stride);
        end
        err_acc -= minor_len;
        // minor step once the error term goes negative
        if (err_acc < 0) begin
            err_acc += major_len;
            if (x_major) begin
                pos_y    += sy;
                addr_acc = addr_acc + (AW+2)'(stride);
            end else begin
                pos_x    += sx;
                addr_acc = addr_acc + (AW+2)'(sx);
            end
        end
        return px;
    endfunction

    task automatic check_pixel();
        t_pixel want;
        if (expected_pixels.size() == 0) begin
            report($sformatf("pixel (%0d,%0d) with none expected", i_pixel_x, i_pixel_y));
            return;
        end
        want = expected_pixels.pop_front();
        if (i_pixel_x !== want.x)
            report($sformatf("pixel_x got %0d want %0d", i_pixel_x, want.x));
        if (i_pixel_y !== want.y)
            report($sformatf("pixel_y got %0d want %0d", i_pixel_y, want.y));
        if (i_pixel_address !== want.address)
            report($sformatf("pixel_address got %0h want %0h at (%0d,%0d)",
                             i_pixel_address, want.address, want.x, want.y));
        if (i_pixel_color !== want.color)
            report($sformatf("pixel_color got %0h want %0h", i_pixel_color, want.color));
        if (i_write_enable !== want.write_en)
            report($sformatf("write_enable got %0b want %0b at (%0d,%0d)",
                             i_write_enable, want.write_en, want.x, want.y));
        if (i_last !== want.is_last)
            report($sformatf("last got %0b want %0b at (%0d,%0d)",
                             i_last, want.is_last, want.x, want.y));
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_walker();
            expected_pixels.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                write_setting(t_reg_idx'(paddr[PADDR_W-1:2]), pwdata[REG_W-1:0]);
            end
            if (push && !full) begin
                if (t_cmd'(i_cmd) == CMD_BEGIN) begin
                    load_line(i_start_x, i_start_y, i_end_x, i_end_y, i_pen_color);
                end else if (line_active) begin
                    expected_pixels.push_back(next_pixel());
                end
            end
            if (pop && !empty) begin
                check_pixel();
            end
        end
        o_pending = expected_pixels.size();
    end

endmodule

[dv/clipped_bresenham_line_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clipped_bresenham_line_test
// Drives begin and advance commands and register writes into the line
// generator with random gaps and pixel-side stalls; a checker beside the
// block predicts and compares every pixel.
// ----------------------------------------------------------------------------
module clipped_bresenham_line_test;
    import clbl_pkg::*;

    localparam int CW              = COORD_BITS_DEF;
    localparam int AW              = ADDR_BITS_DEF;
    localparam int CLK_PERIOD      = 8;
    localparam int DRAIN_CYCLES    = 32;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 130;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [PADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]    pwdata  = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 push    = 1'b0;
    logic                 full;
    logic                 i_cmd   = CMD_BEGIN;
    logic signed [CW-1:0] i_start_x = '0;
    logic signed [CW-1:0] i_start_y = '0;
    logic signed [CW-1:0] i_end_x   = '0;
    logic signed [CW-1:0] i_end_y   = '0;
    logic [15:0]          i_pen_color = '0;
    logic                 pop     = 1'b0;
    logic                 empty;
    logic signed [CW-1:0] o_pixel_x;
    logic signed [CW-1:0] o_pixel_y;
    logic [AW-1:0]        o_pixel_address;
    logic [15:0]          o_pixel_color;
    logic                 o_write_enable;
    logic                 o_last;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int stall_left  = 0;
    bit calm        = 1'b0;
    int area_w      = 320;
    int area_h      = 240;
    int items_sent  = 0;

    clipped_bresenham_line dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .push            (push),
        .full            (full),
        .i_cmd           (i_cmd),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_pen_color     (i_pen_color),
        .pop             (pop),
        .empty           (empty),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_pixel_address (o_pixel_address),
        .o_pixel_color   (o_pixel_color),
        .o_write_enable  (o_write_enable),
        .o_last          (o_last)
    );

    clipped_bresenham_line_check checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .push            (push),
        .full            (full),
        .i_cmd           (i_cmd),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_pen_color     (i_pen_color),
        .pop             (pop),
        .empty           (empty),
        .i_pixel_x       (o_pixel_x),
        .i_pixel_y       (o_pixel_y),
        .i_pixel_address (o_pixel_address),
        .i_pixel_color   (o_pixel_color),
        .i_write_enable  (o_write_enable),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one, none while calm
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // pixel side stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (stall_left != 0) begin
            pop        <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            pop <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 25) begin
                stall_left <= pick_gap();
            end
        end
    end

    // called at a rising edge; push stays high after the transfer
    task automatic send_item(t_cmd c, int sx, int sy, int ex, int ey, int color);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_cmd       <= c;
        i_start_x   <= CW'(sx);
        i_start_y   <= CW'(sy);
        i_end_x     <= CW'(ex);
        i_end_y     <= CW'(ey);
        i_pen_color <= 16'(color);
        do @(posedge i_clk); while (full);
    endtask

    // endpoint and color fields are don't-care on advance, so fill with noise
    task automatic advance_line(int n);
        repeat (n) send_item(CMD_ADVANCE, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        // begins and idle advances leave no pixel behind, let them drain too
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(idx) * 4);
        pwdata  <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setup(int phase);
        int fw, fh, cl, ct, cr, cb;
        case (phase)
            0: begin
                fw = 1;    fh = 1;    cl = 0;    ct = 0;    cr = 1;    cb = 1;
            end
            1: begin
                fw = 1024; fh = 1024; cl = 0;    ct = 0;    cr = 1024; cb = 1024;
            end
            2: begin
                // raw 11-bit maximum beyond the documented range
                fw = 2047; fh = 2047; cl = 0;    ct = 0;    cr = 2047; cb = 2047;
            end
            3: begin
                // empty clip rectangle
                fw = 320;  fh = 240;  cl = 1024; ct = 1024; cr = 0;    cb = 0;
            end
            default: begin
                fw = $urandom_range(1, 1024);
                fh = $urandom_range(1, 1024);
                cl = $urandom_range(0, fw);
                ct = $urandom_range(0, fh);
                cr = $urandom_range(cl, 1024);
                cb = $urandom_range(ct, 1024);
            end
        endcase
        write_reg(REG_FRAME_WIDTH, fw);
        write_reg(REG_FRAME_HEIGHT, fh);
        write_reg(REG_CLIP_LEFT, cl);
        write_reg(REG_CLIP_TOP, ct);
        write_reg(REG_CLIP_RIGHT, cr);
        write_reg(REG_CLIP_BOTTOM, cb);
        area_w = (fw > 1024) ? 1024 : fw;
        area_h = (fh > 1024) ? 1024 : fh;
    endtask

    function automatic int fit_end(int s, int d);
        if (s + d > 2047 || s + d < -2048) begin
            return s - d;
        end
        return s + d;
    endfunction

    task automatic draw_line();
        int sx, sy, ex, ey, span, n, shape, adv;
        if ($urandom_range(0, 19) == 0) begin
            calm <= !calm;
        end
        if ($urandom_range(0, 9) == 0) begin
            sx = $urandom_range(0, 4095) - 2048;
            sy = $urandom_range(0, 4095) - 2048;
        end else begin
            sx = $urandom_range(0, area_w + 8) - 4;
            sy = $urandom_range(0, area_h + 8) - 4;
        end
        span = ($urandom_range(0, 19) == 0) ? 40 : 6;
        ex   = fit_end(sx, $urandom_range(0, 2 * span) - span);
        ey   = fit_end(sy, $urandom_range(0, 2 * span) - span);
        n    = (ex > sx ? ex - sx : sx - ex);
        if ((ey > sy ? ey - sy : sy - ey) > n) begin
            n = (ey > sy ? ey - sy : sy - ey);
        end
        n     = n + 1;
        shape = $urandom_range(0, 9);
        if (shape < 8) begin
            adv = n;
        end else if (shape == 8) begin
            adv = n + $urandom_range(1, 2);    // runs past the end point
        end else begin
            adv = $urandom_range(0, n - 1);    // cut short by the next begin
        end
        send_item(CMD_BEGIN, sx, sy, ex, ey, $urandom);
        advance_line(adv);
        items_sent += adv + 1;
    endtask

    initial begin
        int target;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // advance with no line loaded
        advance_line(1);
        // single point line, then one advance past its end
        send_item(CMD_BEGIN, 0, 0, 0, 0, 16'hFFFF);
        advance_line(2);
        // coordinate extremes, restarted after two pixels
        send_item(CMD_BEGIN, -2048, -2048, 2047, 2047, 16'h0000);
        advance_line(2);
        send_item(CMD_BEGIN, 2047, -2048, -2048, 2047, 16'h5A5A);
        advance_line(2);
        // steep line going up and left
        send_item(CMD_BEGIN, 4, 4, 3, 0, 16'h1234);
        advance_line(5);
        // shallow line crossing the right and bottom clip edges
        send_item(CMD_BEGIN, 318, 239, 322, 241, 16'hA5C3);
        advance_line(5);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            apply_setup(phase);
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 3)) begin
                        send_item(t_cmd'($urandom_range(0, 1)), $urandom, $urandom,
                                  $urandom, $urandom, $urandom);
                    end
                end else begin
                    draw_line();
                end
            end
        end
        wait_idle();

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
